>>> design/ill_pkg.sv
// Shared types and constants for the indexed linked list core.
// Holds the request/result payload structs, request and status codes and FSM state types.
// No dependencies.
package ill_pkg;

  // Fixed field widths of the request and result payloads.
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 10;
  localparam int TYPE_W   = 3;
  localparam int STATUS_W = 2;

  // Request kinds.
  localparam logic [TYPE_W-1:0] REQ_GET      = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_ADD_HEAD = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_ADD_TAIL = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_ADD_POS  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Value returned by a get that misses.
  localparam logic signed [VALUE_W-1:0] READ_MISS = -32'sd1;

  typedef struct packed {
    logic [TYPE_W-1:0]         req_type;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
  } rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_ALLOC_W,
    S_PLACE,
    S_WALK_GO,
    S_WALK,
    S_INS_W1,
    S_INS_W2,
    S_DEL_RD,
    S_DEL_NX,
    S_FREE,
    S_GET_RD,
    S_GET_V,
    S_DONE
  } state_t;

  // Operation that a link walk serves.
  typedef enum logic [1:0] {
    OP_GET,
    OP_INS,
    OP_DEL
  } op_t;

  // Where a new entry is spliced in.
  typedef enum logic [1:0] {
    INS_EMPTY,
    INS_HEAD,
    INS_TAIL,
    INS_MID
  } ins_kind_t;

endpackage

>>> design/indexed_linked_list_core.sv
// Top level of the indexed linked list: request/result handshakes and the list sequencer.
// Uses ill_pkg for payload types and codes and ill_store for the value and link memories.
//
//   Channel | Ports                            | Payload
//   in      | in_valid, in_ready, in_data      | req_t: req_type, position, new_value
//   out     | out_valid, out_ready, out_data   | rsp_t: read_value, status
//
// A get or a delete walks position links from the head, and so does an insert in the middle;
// head and tail inserts do not walk, and rejected requests go straight to the result.
// Taking a slot off the free stack adds the S_ALLOC_W state to an insert. The walk chases
// the link memory read port, one link per cycle. One request is in work at a time.
// Reset (rst_n, synchronous) empties the list; the memories hold no reset value.
// A result waiting on out_ready stalls the sequencer only when the next one is ready.
module indexed_linked_list_core #(
  parameter int CAPACITY = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ill_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ill_pkg::rsp_t out_data
);
  import ill_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Control state.
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] free_top_r, free_top_nxt;
  logic [CNT_W-1:0]  free_count_r, free_count_nxt;
  logic [CNT_W-1:0]  fresh_r, fresh_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers of the request in progress.
  req_t              req_r, req_nxt;
  op_t               op_r, op_nxt;
  ins_kind_t         ins_kind_r, ins_kind_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [SLOT_W-1:0] prev_r, prev_nxt;
  logic [SLOT_W-1:0] new_slot_r, new_slot_nxt;
  logic [CMP_W-1:0]  walk_left_r, walk_left_nxt;
  logic signed [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  rsp_t              out_data_r, out_data_nxt;

  // Memory ports.
  logic              link_we;
  logic [SLOT_W-1:0] link_waddr, link_wdata, link_raddr, link_q;
  logic              value_we;
  logic signed [VALUE_W-1:0] value_q;

  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              full;
  state_t            walk_done_state;

  assign pos_ext = CMP_W'(req_r.position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r >= CNT_W'(CAPACITY));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ill_store #(
    .DEPTH  (CAPACITY),
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk         (clk),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .link_raddr  (link_raddr),
    .link_rdata  (link_q),
    .value_we    (value_we),
    .value_waddr (new_slot_nxt),
    .value_wdata (req_r.new_value),
    .value_raddr (cur_r),
    .value_rdata (value_q)
  );

  // Where a finished walk continues.
  always_comb begin
    case (op_r)
      OP_GET:  walk_done_state = S_GET_RD;
      OP_INS:  walk_done_state = S_INS_W1;
      OP_DEL:  walk_done_state = S_DEL_RD;
      default: walk_done_state = S_GET_RD;
    endcase
  end

  // Sequencer: next state, list pointers and memory accesses.
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    free_top_nxt   = free_top_r;
    free_count_nxt = free_count_r;
    fresh_nxt      = fresh_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    req_nxt        = req_r;
    op_nxt         = op_r;
    ins_kind_nxt   = ins_kind_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    new_slot_nxt   = new_slot_r;
    walk_left_nxt  = walk_left_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    link_we        = 1'b0;
    link_waddr     = new_slot_r;
    link_wdata     = cur_r;
    link_raddr     = cur_r;
    value_we       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DECODE;
        end
      end

      // Range and capacity checks pick the path of the request.
      S_DECODE: begin
        res_value_nxt  = '0;
        res_status_nxt = ST_DONE;
        cur_nxt        = head_r;
        walk_left_nxt  = pos_ext;
        state_nxt      = S_DONE;
        case (req_r.req_type)
          REQ_GET: begin
            if (pos_ext < cnt_ext) begin
              op_nxt    = OP_GET;
              state_nxt = S_WALK_GO;
            end else begin
              res_value_nxt  = READ_MISS;
              res_status_nxt = ST_RANGE;
            end
          end
          REQ_ADD_HEAD: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              op_nxt        = OP_INS;
              walk_left_nxt = '0;
              state_nxt     = S_ALLOC;
            end
          end
          REQ_ADD_TAIL: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              op_nxt        = OP_INS;
              walk_left_nxt = cnt_ext;
              state_nxt     = S_ALLOC;
            end
          end
          REQ_ADD_POS: begin
            if (pos_ext > cnt_ext) begin
              res_status_nxt = ST_RANGE;
            end else if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              op_nxt    = OP_INS;
              state_nxt = S_ALLOC;
            end
          end
          REQ_DELETE: begin
            if (pos_ext >= cnt_ext) begin
              res_status_nxt = ST_RANGE;
            end else begin
              op_nxt    = OP_DEL;
              state_nxt = S_WALK_GO;
            end
          end
          default: begin
            res_status_nxt = ST_RANGE;
          end
        endcase
      end

      // Take a slot from the free stack or the never-used range, and store the value.
      S_ALLOC: begin
        value_we = 1'b1;
        if (free_count_r != '0) begin
          new_slot_nxt = free_top_r;
          link_raddr   = free_top_r;
          state_nxt    = S_ALLOC_W;
        end else begin
          new_slot_nxt = fresh_r[SLOT_W-1:0];
          fresh_nxt    = fresh_r + CNT_W'(1);
          state_nxt    = S_PLACE;
        end
      end

      // Pop the free stack once its link has been read.
      S_ALLOC_W: begin
        free_top_nxt   = link_q;
        free_count_nxt = free_count_r - CNT_W'(1);
        state_nxt      = S_PLACE;
      end

      // Choose the splice point of the new entry.
      S_PLACE: begin
        state_nxt = S_INS_W1;
        if (count_r == '0) begin
          ins_kind_nxt = INS_EMPTY;
          cur_nxt      = '0;
        end else if (walk_left_r == '0) begin
          ins_kind_nxt = INS_HEAD;
          cur_nxt      = head_r;
        end else if (walk_left_r == cnt_ext) begin
          ins_kind_nxt = INS_TAIL;
          cur_nxt      = '0;
          prev_nxt     = tail_r;
        end else begin
          ins_kind_nxt = INS_MID;
          cur_nxt      = head_r;
          state_nxt    = S_WALK_GO;
        end
      end

      // Start a walk of walk_left links from cur.
      S_WALK_GO: begin
        if (walk_left_r == '0) begin
          state_nxt = walk_done_state;
        end else begin
          link_raddr = cur_r;
          state_nxt  = S_WALK;
        end
      end

      // One link per cycle: the returned link addresses the next read directly.
      S_WALK: begin
        cur_nxt       = link_q;
        prev_nxt      = cur_r;
        walk_left_nxt = walk_left_r - CMP_W'(1);
        link_raddr    = link_q;
        if (walk_left_r == CMP_W'(1)) begin
          state_nxt = walk_done_state;
        end
      end

      // Link the new entry to its successor and update the ends.
      S_INS_W1: begin
        link_we    = 1'b1;
        link_waddr = new_slot_r;
        link_wdata = cur_r;
        count_nxt  = count_r + CNT_W'(1);
        state_nxt  = S_DONE;
        case (ins_kind_r)
          INS_EMPTY: begin
            head_nxt = new_slot_r;
            tail_nxt = new_slot_r;
          end
          INS_HEAD: begin
            head_nxt = new_slot_r;
          end
          INS_TAIL: begin
            tail_nxt  = new_slot_r;
            state_nxt = S_INS_W2;
          end
          INS_MID: begin
            state_nxt = S_INS_W2;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Point the predecessor at the new entry.
      S_INS_W2: begin
        link_we    = 1'b1;
        link_waddr = prev_r;
        link_wdata = new_slot_r;
        state_nxt  = S_DONE;
      end

      // Read the victim's successor.
      S_DEL_RD: begin
        link_raddr = cur_r;
        state_nxt  = S_DEL_NX;
      end

      // Unlink the victim and fix the ends.
      S_DEL_NX: begin
        if (req_r.position == '0) begin
          head_nxt = link_q;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_r;
          link_wdata = link_q;
          if (pos_ext + CMP_W'(1) == cnt_ext) begin
            tail_nxt = prev_r;
          end
        end
        count_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
        state_nxt = S_FREE;
      end

      // Push the victim onto the free stack.
      S_FREE: begin
        link_we        = 1'b1;
        link_waddr     = cur_r;
        link_wdata     = free_top_r;
        free_top_nxt   = cur_r;
        free_count_nxt = free_count_r + CNT_W'(1);
        state_nxt      = S_DONE;
      end

      // The value read of the target slot is in flight.
      S_GET_RD: begin
        state_nxt = S_GET_V;
      end

      S_GET_V: begin
        res_value_nxt = value_q;
        state_nxt     = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = res_value_r;
          out_data_nxt.status     = res_status_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      free_top_r   <= '0;
      free_count_r <= '0;
      fresh_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      free_top_r   <= free_top_nxt;
      free_count_r <= free_count_nxt;
      fresh_r      <= fresh_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    op_r         <= op_nxt;
    ins_kind_r   <= ins_kind_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    new_slot_r   <= new_slot_nxt;
    walk_left_r  <= walk_left_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

>>> design/ill_store.sv
// Value and link memories of the linked list, one write and one read port each.
// Read data is registered. Depends on ill_pkg.
module ill_store #(
  parameter int DEPTH  = 1024,
  parameter int SLOT_W = 10
) (
  input  logic                          clk,
  input  logic                          link_we,
  input  logic [SLOT_W-1:0]             link_waddr,
  input  logic [SLOT_W-1:0]             link_wdata,
  input  logic [SLOT_W-1:0]             link_raddr,
  output logic [SLOT_W-1:0]             link_rdata,
  input  logic                          value_we,
  input  logic [SLOT_W-1:0]             value_waddr,
  input  logic signed [ill_pkg::VALUE_W-1:0] value_wdata,
  input  logic [SLOT_W-1:0]             value_raddr,
  output logic signed [ill_pkg::VALUE_W-1:0] value_rdata
);
  import ill_pkg::*;

  logic [SLOT_W-1:0]  link_mem  [DEPTH];
  logic [VALUE_W-1:0] value_mem [DEPTH];

  // Link memory: successor slot of each entry, also threads the free stack.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  // Value memory: the stored data of each slot.
  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_waddr] <= value_wdata;
    end
    value_rdata <= value_mem[value_raddr];
  end

endmodule
